/* hw/rtl/mpcd_pkg.sv */
package mpcd_pkg;

  // default directory size
  localparam int unsigned NUM_ENTRIES_DEF = 32;

  // fixed field widths
  localparam int unsigned KEY_W     = 16;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned CTR_W     = 32;
  localparam int unsigned POL_W     = 3;
  localparam int unsigned SEED_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = SEED_W;

  // random victim generator
  localparam int unsigned   LFSR_W    = 16;
  localparam logic [15:0]   LFSR_TAPS = 16'hB400;

  localparam logic [CTR_W-1:0] CTR_MAX = {CTR_W{1'b1}};

  // replacement rules, codes five to seven behave as oldest
  typedef enum logic [POL_W-1:0] {
    POL_LFU  = 3'd0,
    POL_MFU  = 3'd1,
    POL_MRU  = 3'd2,
    POL_LRU  = 3'd3,
    POL_RAND = 3'd4
  } policy_e;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLICY = 2'd0,
    REG_SEED   = 2'd1
  } reg_idx_e;

  // control into the shared entry unit
  typedef struct packed {
    logic upd;  // second sweep: install new entry, age the rest
    logic sel;  // entry is the matching or the installed one
  } alu_ctrl_t;

endpackage

/* hw/rtl/mpcd_ram.sv */
module mpcd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/mpcd_alu.sv */
module mpcd_alu import mpcd_pkg::*; (
  input  alu_ctrl_t        ctrl_i,
  input  logic [POL_W-1:0] policy_i,
  input  logic [CTR_W-1:0] count_i,
  input  logic [CTR_W-1:0] age_i,
  input  logic [CTR_W-1:0] best_i,
  output logic [CTR_W-1:0] count_o,
  output logic [CTR_W-1:0] age_o,
  output logic [CTR_W-1:0] metric_o,
  output logic             better_o
);

  logic [CTR_W-1:0] cnt_inc;
  logic [CTR_W-1:0] age_inc;
  logic             want_lt;
  logic             use_cnt;
  logic [CTR_W-1:0] cmp_a;
  logic [CTR_W-1:0] cmp_b;

  // saturating counters
  assign cnt_inc = (count_i == CTR_MAX) ? count_i : count_i + CTR_W'(1);
  assign age_inc = (age_i == CTR_MAX) ? age_i : age_i + CTR_W'(1);

  always_comb begin
    if (ctrl_i.sel) begin
      count_o = ctrl_i.upd ? CTR_W'(1) : cnt_inc;
      age_o   = '0;
    end else begin
      count_o = count_i;
      age_o   = age_inc;
    end
  end

  assign use_cnt  = (policy_i == POL_LFU) || (policy_i == POL_MFU);
  assign want_lt  = (policy_i == POL_LFU) || (policy_i == POL_MRU);
  assign metric_o = use_cnt ? count_o : age_o;

  // one comparator, operands swapped for the greater-than rules
  assign cmp_a    = want_lt ? metric_o : best_i;
  assign cmp_b    = want_lt ? best_i : metric_o;
  assign better_o = cmp_a < cmp_b;

endmodule

/* hw/rtl/mpcd_rand.sv */
module mpcd_rand import mpcd_pkg::*; #(
  parameter int unsigned NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           seed_we_i,
  input  logic [SEED_W-1:0]              seed_i,
  input  logic                           start_i,
  output logic                           done_o,
  output logic [$clog2(NUM_ENTRIES)-1:0] victim_o
);

  localparam int unsigned IDX_W = $clog2(NUM_ENTRIES);
  // reciprocal of the directory size, rounded up, exact for every lfsr word
  localparam int unsigned SHIFT = LFSR_W + IDX_W;
  localparam int unsigned RCP_W = LFSR_W + 1;
  localparam int unsigned PRD_W = LFSR_W + RCP_W;
  localparam int unsigned QUO_W = PRD_W - SHIFT;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << SHIFT) + 64'(NUM_ENTRIES) - 64'd1) / 64'(NUM_ENTRIES));

  logic [LFSR_W-1:0] lfsr_q, lfsr_d;
  logic [PRD_W-1:0]  prod_q, prod_d;
  logic [IDX_W-1:0]  rem_q, rem_d;
  logic              mul_q, mul_d;
  logic              sub_q, sub_d;
  logic              done_q, done_d;
  logic [LFSR_W-1:0] lfsr_next;
  logic [QUO_W-1:0]  quot;
  logic [LFSR_W-1:0] quot_n;

  // galois step, shifting right
  assign lfsr_next = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);

  // quotient from the reciprocal product, then the remainder
  assign quot   = prod_q[PRD_W-1:SHIFT];
  assign quot_n = LFSR_W'(quot) * LFSR_W'(NUM_ENTRIES);

  always_comb begin
    lfsr_d = lfsr_q;
    prod_d = prod_q;
    rem_d  = rem_q;
    mul_d  = 1'b0;
    sub_d  = 1'b0;
    done_d = 1'b0;
    if (seed_we_i) begin
      lfsr_d = (seed_i == '0) ? LFSR_W'(1) : seed_i;
    end else if (start_i) begin
      lfsr_d = lfsr_next;
      mul_d  = 1'b1;
    end
    if (mul_q) begin
      prod_d = PRD_W'(lfsr_q) * PRD_W'(RECIP);
      sub_d  = 1'b1;
    end
    if (sub_q) begin
      rem_d  = IDX_W'(lfsr_q - quot_n);
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= LFSR_W'(1);
      mul_q  <= 1'b0;
      sub_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      lfsr_q <= lfsr_d;
      mul_q  <= mul_d;
      sub_q  <= sub_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign done_o   = done_q;
  assign victim_o = rem_q;

endmodule

/* hw/rtl/multi_policy_cache_directory.sv */
// sequence: a hit answers after the first sweep over the entry memories, a miss
//   after a second sweep; an eviction reads the victim key between the sweeps,
//   and a random eviction first waits for the random victim generator
// throughput: one request at a time, each sweep handles one entry per cycle
// reset: all entries empty, policy oldest, random generator loaded with 1;
//   no clearing pass, entry validity lives in flip-flops
module multi_policy_cache_directory import mpcd_pkg::*; #(
  parameter int unsigned NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // request words
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  logic [KEY_W-1:0]     request_key_i,
  // response words
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  output logic                 hit_o,
  output logic [SLOT_W-1:0]    slot_index_o,
  output logic                 evicted_o,
  output logic [KEY_W-1:0]     evicted_key_o
);

  localparam int unsigned IDX_W = $clog2(NUM_ENTRIES);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_ENTRIES);

  // sequencer states
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SCAN   = 8'b0000_0010,
    ST_DECIDE = 8'b0000_0100,
    ST_RAND   = 8'b0000_1000,
    ST_KRD    = 8'b0001_0000,
    ST_KCAP   = 8'b0010_0000,
    ST_UPD    = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // sweep control: issue counter and the data stage behind the ram read
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   p_valid_q, p_valid_d;
  logic [IDX_W-1:0]       p_idx_q, p_idx_d;

  logic [NUM_ENTRIES-1:0] valid_q, valid_d;
  logic [POL_W-1:0]       policy_q, policy_d;

  logic                   hit_found_q, hit_found_d;
  logic                   empty_found_q, empty_found_d;
  logic                   rsp_valid_q, rsp_valid_d;

  // working payload
  logic [KEY_W-1:0]       req_key_q, req_key_d;
  logic [IDX_W-1:0]       hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0]       empty_idx_q, empty_idx_d;
  logic [IDX_W-1:0]       best_idx_q, best_idx_d;
  logic [CTR_W-1:0]       best_val_q, best_val_d;
  logic [IDX_W-1:0]       slot_q, slot_d;
  logic                   evicted_q, evicted_d;
  logic [KEY_W-1:0]       evkey_q, evkey_d;

  // response registers
  logic                   rsp_hit_q, rsp_hit_d;
  logic [SLOT_W-1:0]      rsp_slot_q, rsp_slot_d;
  logic                   rsp_ev_q, rsp_ev_d;
  logic [KEY_W-1:0]       rsp_evkey_q, rsp_evkey_d;

  // entry memories
  logic [IDX_W-1:0]       rd_addr;
  logic [KEY_W-1:0]       key_rd;
  logic [CTR_W-1:0]       cnt_rd;
  logic [CTR_W-1:0]       age_rd;
  logic                   key_we;
  logic                   ctr_we;

  // shared entry unit
  alu_ctrl_t              alu_ctrl;
  logic                   ent_valid;
  logic [CTR_W-1:0]       eff_cnt;
  logic [CTR_W-1:0]       eff_age;
  logic [CTR_W-1:0]       new_cnt;
  logic [CTR_W-1:0]       new_age;
  logic [CTR_W-1:0]       metric;
  logic                   better;

  // random victim unit
  logic                   seed_we;
  logic                   rand_start;
  logic                   rand_done;
  logic [IDX_W-1:0]       rand_victim;

  logic                   in_sweep;
  logic                   issue;
  logic                   is_upd;

  assign req_ready_o = (state_q == ST_IDLE);

  assign in_sweep = (state_q == ST_SCAN) || (state_q == ST_UPD);
  assign issue    = in_sweep && (cnt_q != CNT_END);
  assign is_upd   = (state_q == ST_UPD);

  // the key read for the eviction report borrows the read port
  assign rd_addr  = (state_q == ST_KRD) ? slot_q : cnt_q[IDX_W-1:0];

  // entries never written read as zero
  assign ent_valid = valid_q[p_idx_q];
  assign eff_cnt   = ent_valid ? cnt_rd : '0;
  assign eff_age   = ent_valid ? age_rd : '0;

  assign alu_ctrl.upd = is_upd;
  assign alu_ctrl.sel = is_upd ? (p_idx_q == slot_q)
                               : (ent_valid && (key_rd == req_key_q));

  assign ctr_we = p_valid_q;
  assign key_we = p_valid_q && is_upd && alu_ctrl.sel;

  assign seed_we = cfg_we_i && (cfg_idx_i == REG_SEED);

  mpcd_ram #(.WIDTH(KEY_W), .DEPTH(NUM_ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (p_idx_q),
    .wdata_i (req_key_q),
    .raddr_i (rd_addr),
    .rdata_o (key_rd)
  );

  mpcd_ram #(.WIDTH(CTR_W), .DEPTH(NUM_ENTRIES)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (ctr_we),
    .waddr_i (p_idx_q),
    .wdata_i (new_cnt),
    .raddr_i (rd_addr),
    .rdata_o (cnt_rd)
  );

  mpcd_ram #(.WIDTH(CTR_W), .DEPTH(NUM_ENTRIES)) u_age_ram (
    .clk_i   (clk_i),
    .we_i    (ctr_we),
    .waddr_i (p_idx_q),
    .wdata_i (new_age),
    .raddr_i (rd_addr),
    .rdata_o (age_rd)
  );

  mpcd_alu u_alu (
    .ctrl_i   (alu_ctrl),
    .policy_i (policy_q),
    .count_i  (eff_cnt),
    .age_i    (eff_age),
    .best_i   (best_val_q),
    .count_o  (new_cnt),
    .age_o    (new_age),
    .metric_o (metric),
    .better_o (better)
  );

  mpcd_rand #(.NUM_ENTRIES(NUM_ENTRIES)) u_rand (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seed_we_i (seed_we),
    .seed_i    (cfg_wdata_i[SEED_W-1:0]),
    .start_i   (rand_start),
    .done_o    (rand_done),
    .victim_o  (rand_victim)
  );

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    p_valid_d     = 1'b0;
    p_idx_d       = p_idx_q;
    valid_d       = valid_q;
    policy_d      = policy_q;
    hit_found_d   = hit_found_q;
    empty_found_d = empty_found_q;
    rsp_valid_d   = rsp_valid_q;
    req_key_d     = req_key_q;
    hit_idx_d     = hit_idx_q;
    empty_idx_d   = empty_idx_q;
    best_idx_d    = best_idx_q;
    best_val_d    = best_val_q;
    slot_d        = slot_q;
    evicted_d     = evicted_q;
    evkey_d       = evkey_q;
    rsp_hit_d     = rsp_hit_q;
    rsp_slot_d    = rsp_slot_q;
    rsp_ev_d      = rsp_ev_q;
    rsp_evkey_d   = rsp_evkey_q;
    rand_start    = 1'b0;

    // policy register, to be written only while idle; the block does not enforce this
    if (cfg_we_i && (cfg_idx_i == REG_POLICY)) begin
      policy_d = cfg_wdata_i[POL_W-1:0];
    end

    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end

    // issue side of a sweep
    if (issue) begin
      cnt_d     = cnt_q + CNT_W'(1);
      p_valid_d = 1'b1;
      p_idx_d   = cnt_q[IDX_W-1:0];
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          req_key_d     = request_key_i;
          cnt_d         = '0;
          hit_found_d   = 1'b0;
          empty_found_d = 1'b0;
          state_d       = ST_SCAN;
        end
      end

      // first sweep: match, age, find the first empty slot and the victim
      ST_SCAN: begin
        if (p_valid_q) begin
          if (alu_ctrl.sel) begin
            hit_found_d = 1'b1;
            hit_idx_d   = p_idx_q;
          end
          if (!ent_valid && !empty_found_q) begin
            empty_found_d = 1'b1;
            empty_idx_d   = p_idx_q;
          end
          // strict compare keeps the lowest slot on a tie
          if ((p_idx_q == '0) || better) begin
            best_idx_d = p_idx_q;
            best_val_d = metric;
          end
          if (p_idx_q == LAST_IDX) begin
            state_d = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        cnt_d = '0;
        if (hit_found_q) begin
          slot_d    = hit_idx_q;
          evicted_d = 1'b0;
          evkey_d   = '0;
          state_d   = ST_DONE;
        end else if (empty_found_q) begin
          slot_d    = empty_idx_q;
          evicted_d = 1'b0;
          evkey_d   = '0;
          state_d   = ST_UPD;
        end else if (policy_q == POL_RAND) begin
          rand_start = 1'b1;
          state_d    = ST_RAND;
        end else begin
          slot_d    = best_idx_q;
          evicted_d = 1'b1;
          state_d   = ST_KRD;
        end
      end

      ST_RAND: begin
        if (rand_done) begin
          slot_d    = rand_victim;
          evicted_d = 1'b1;
          state_d   = ST_KRD;
        end
      end

      ST_KRD: begin
        state_d = ST_KCAP;
      end

      ST_KCAP: begin
        evkey_d = key_rd;
        cnt_d   = '0;
        state_d = ST_UPD;
      end

      // second sweep: install the new entry, age every other one
      ST_UPD: begin
        if (p_valid_q) begin
          if (alu_ctrl.sel) begin
            valid_d[p_idx_q] = 1'b1;
          end
          if (p_idx_q == LAST_IDX) begin
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_valid_d = 1'b1;
          rsp_hit_d   = hit_found_q;
          rsp_slot_d  = SLOT_W'(slot_q);
          rsp_ev_d    = evicted_q;
          rsp_evkey_d = evkey_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      p_valid_q     <= 1'b0;
      p_idx_q       <= '0;
      valid_q       <= '0;
      policy_q      <= POL_LRU;
      hit_found_q   <= 1'b0;
      empty_found_q <= 1'b0;
      rsp_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      p_valid_q     <= p_valid_d;
      p_idx_q       <= p_idx_d;
      valid_q       <= valid_d;
      policy_q      <= policy_d;
      hit_found_q   <= hit_found_d;
      empty_found_q <= empty_found_d;
      rsp_valid_q   <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_key_q   <= req_key_d;
    hit_idx_q   <= hit_idx_d;
    empty_idx_q <= empty_idx_d;
    best_idx_q  <= best_idx_d;
    best_val_q  <= best_val_d;
    slot_q      <= slot_d;
    evicted_q   <= evicted_d;
    evkey_q     <= evkey_d;
    rsp_hit_q   <= rsp_hit_d;
    rsp_slot_q  <= rsp_slot_d;
    rsp_ev_q    <= rsp_ev_d;
    rsp_evkey_q <= rsp_evkey_d;
  end

  assign rsp_valid_o   = rsp_valid_q;
  assign hit_o         = rsp_hit_q;
  assign slot_index_o  = rsp_slot_q;
  assign evicted_o     = rsp_ev_q;
  assign evicted_key_o = rsp_evkey_q;

endmodule

/* hw/rtl/mpcd_chk.sv */
module mpcd_chk import mpcd_pkg::*; #(
  parameter int unsigned NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 req_valid_i,
  input logic                 req_ready_o,
  input logic                 rsp_valid_o,
  input logic                 rsp_ready_i,
  input logic                 hit_o,
  input logic [SLOT_W-1:0]    slot_index_o,
  input logic                 evicted_o,
  input logic [KEY_W-1:0]     evicted_key_o
);

  // a held response word keeps its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(hit_o)
      && $stable(slot_index_o) && $stable(evicted_o) && $stable(evicted_key_o))
    else $error("response word changed while stalled");

  // an accepted request takes the block out of the ready state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("request taken while a lookup is in progress");

  // a hit never replaces an entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && hit_o |-> !evicted_o)
    else $error("eviction reported on a hit");

  // no eviction, no evicted key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !evicted_o |-> evicted_key_o == '0)
    else $error("evicted key set without eviction");

  // slot lies inside the directory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> {1'b0, slot_index_o} < (SLOT_W + 1)'(NUM_ENTRIES))
    else $error("slot index beyond directory size");

endmodule

bind multi_policy_cache_directory mpcd_chk #(.NUM_ENTRIES(NUM_ENTRIES)) u_mpcd_chk (.*);

/* dv/multi_policy_cache_directory_tb.sv */
`timescale 1ns / 1ps

module multi_policy_cache_directory_tb;
  import mpcd_pkg::*;

  localparam int unsigned ENTRIES         = NUM_ENTRIES_DEF;
  // slowest lookup is a random eviction
  localparam int unsigned LOOKUP_LAT      = 2 * ENTRIES + 6 + 3;
  localparam int unsigned TAIL_CYCLES     = LOOKUP_LAT + 16;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned BURST_WORDS     = 30;
  localparam int unsigned PHASE_WORDS     = 135;
  localparam int unsigned NUM_PHASES      = 10;
  // no handshake for this long means the block is stuck
  localparam int unsigned WATCHDOG_LIMIT  = 4000;

  // policy codes outside the defined set, these fall back to oldest
  localparam logic [POL_W-1:0] POL_SPARE5 = 3'd5;
  localparam logic [POL_W-1:0] POL_SPARE6 = 3'd6;
  localparam logic [POL_W-1:0] POL_SPARE7 = 3'd7;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [KEY_W-1:0]  victim_key;
  } lookup_reply_t;

  // directory predictor plus the queue of replies still owed by the block
  class lookup_scoreboard;
    bit                 slot_used [ENTRIES];
    logic [KEY_W-1:0]   slot_key  [ENTRIES];
    logic [CTR_W-1:0]   uses      [ENTRIES];
    logic [CTR_W-1:0]   ages      [ENTRIES];
    logic [POL_W-1:0]   policy;
    logic [LFSR_W-1:0]  lfsr;
    lookup_reply_t      owed_replies [$];
    int                 errors;
    int                 hits;
    int                 fills;
    int                 evictions;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
        uses[i]      = '0;
        ages[i]      = '0;
      end
      policy    = POL_LRU;
      lfsr      = LFSR_W'(1);
      errors    = 0;
      hits      = 0;
      fills     = 0;
      evictions = 0;
    endfunction

    function logic [CTR_W-1:0] sat_inc(logic [CTR_W-1:0] v);
      return (v == CTR_MAX) ? v : v + 1'b1;
    endfunction

    // one pass: match refreshes and counts, everything else ages
    function int sweep(logic [KEY_W-1:0] key);
      int found;
      found = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_used[i] && slot_key[i] == key) begin
          uses[i] = sat_inc(uses[i]);
          ages[i] = '0;
          found   = i;
        end else begin
          ages[i] = sat_inc(ages[i]);
        end
      end
      return found;
    endfunction

    function int pick_victim();
      int   best;
      logic lsb;
      logic better;
      best = 0;
      if (policy == POL_RAND) begin
        lsb  = lfsr[0];
        lfsr = lfsr >> 1;
        if (lsb) lfsr = lfsr ^ LFSR_TAPS;
        return int'(lfsr % ENTRIES);
      end
      for (int i = 1; i < ENTRIES; i++) begin
        case (policy)
          POL_LFU: better = uses[i] < uses[best];
          POL_MFU: better = uses[i] > uses[best];
          POL_MRU: better = ages[i] < ages[best];
          default: better = ages[i] > ages[best];
        endcase
        if (better) best = i;
      end
      return best;
    endfunction

    function lookup_reply_t predict_lookup(logic [KEY_W-1:0] key);
      lookup_reply_t r;
      int            slot;
      r    = '0;
      slot = sweep(key);
      if (slot >= 0) begin
        r.hit = 1'b1;
        hits++;
      end else begin
        for (int i = 0; i < ENTRIES && slot < 0; i++)
          if (!slot_used[i]) slot = i;
        if (slot < 0) begin
          slot         = pick_victim();
          r.evicted    = 1'b1;
          r.victim_key = slot_key[slot];
          evictions++;
        end else begin
          fills++;
        end
        slot_used[slot] = 1'b1;
        slot_key[slot]  = key;
        uses[slot]      = '0;
        ages[slot]      = '0;
        void'(sweep(key));
      end
      r.slot = SLOT_W'(slot);
      return r;
    endfunction

    function void note_lookup(logic [KEY_W-1:0] key);
      owed_replies.push_back(predict_lookup(key));
    endfunction

    function void check_reply(logic h, logic [SLOT_W-1:0] s, logic e, logic [KEY_W-1:0] k);
      lookup_reply_t exp_r;
      if (owed_replies.size() == 0) begin
        $error("reply word with no lookup outstanding");
        errors++;
        return;
      end
      exp_r = owed_replies.pop_front();
      if (h !== exp_r.hit) begin
        $error("hit: expected %0d, got %0d", exp_r.hit, h);
        errors++;
      end
      if (s !== exp_r.slot) begin
        $error("slot_index: expected %0d, got %0d", exp_r.slot, s);
        errors++;
      end
      if (e !== exp_r.evicted) begin
        $error("evicted: expected %0d, got %0d", exp_r.evicted, e);
        errors++;
      end
      if (k !== exp_r.victim_key) begin
        $error("evicted_key: expected 0x%04h, got 0x%04h", exp_r.victim_key, k);
        errors++;
      end
    endfunction

    function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_POLICY: policy = data[POL_W-1:0];
        // a zero seed would lock the generator, so it loads one
        REG_SEED:   lfsr = (data == '0) ? LFSR_W'(1) : LFSR_W'(data);
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_replies.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 req_valid;
  logic                 req_ready;
  logic [KEY_W-1:0]     request_key;
  logic                 rsp_valid;
  logic                 rsp_ready;
  logic                 hit;
  logic [SLOT_W-1:0]    slot_index;
  logic                 evicted;
  logic [KEY_W-1:0]     evicted_key;

  lookup_scoreboard sb;

  // idling percentages for both sides, changed per phase by the main sequence
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // request for one long receiver hold-off, cleared by the receiver process
  bit          hold_off_go   = 1'b0;
  int          settings_seen = 0;

  multi_policy_cache_directory dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .req_valid_i   (req_valid),
    .req_ready_o   (req_ready),
    .request_key_i (request_key),
    .rsp_valid_o   (rsp_valid),
    .rsp_ready_i   (rsp_ready),
    .hit_o         (hit),
    .slot_index_o  (slot_index),
    .evicted_o     (evicted),
    .evicted_key_o (evicted_key)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // monitor: every accepted request word feeds the predictor, every accepted
  // reply word is checked against the oldest owed reply
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_valid && req_ready) sb.note_lookup(request_key);
      if (rsp_valid && rsp_ready) sb.check_reply(hit, slot_index, evicted, evicted_key);
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request,
  // counted here so the sender keeps pushing and the block backs up
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        for (int c = 0; c < HOLD_OFF_CYCLES; c++) begin
          rsp_ready <= 1'b0;
          @(posedge clk);
        end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: ends the run if no word moves on either channel for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // register write, only issued while the block is idle; the extra edge
  // keeps the enable from being lowered and raised in one step
  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.apply_config(idx, data);
    settings_seen++;
    @(posedge clk);
  endtask

  // offer one request word, with an optional random gap in front of it;
  // valid stays up across back-to-back words
  task automatic send_lookup(logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    request_key <= key;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // sender pauses until the block has answered everything
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // keys mostly come from a drifting working set so that hits, refills and
  // every victim rule get exercised; a few are fresh or extreme values
  task automatic run_lookups(int unsigned count, int unsigned pool_size);
    logic [KEY_W-1:0] pool [128];
    logic [KEY_W-1:0] key;
    int unsigned      r;
    for (int i = 0; i < pool_size; i++) pool[i] = KEY_W'($urandom);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 8)       key = KEY_W'($urandom);
      else if (r < 10) key = $urandom_range(1) ? '1 : '0;
      else             key = pool[$urandom_range(pool_size - 1)];
      if ($urandom_range(19) == 0) pool[$urandom_range(pool_size - 1)] = KEY_W'($urandom);
      send_lookup(key);
    end
  endtask

  // long receiver stall while the sender keeps offering words
  task automatic pressure_burst();
    int unsigned saved_pct;
    saved_pct     = send_idle_pct;
    send_idle_pct = 0;
    hold_off_go   = 1'b1;
    for (int n = 0; n < BURST_WORDS; n++) send_lookup(KEY_W'($urandom_range(47)));
    send_idle_pct = saved_pct;
  endtask

  initial begin
    logic [POL_W-1:0]  pol;
    logic [CFG_W-1:0]  seed;
    logic [CFG_W-1:0]  pol_word;
    logic [KEY_W-1:0]  directed [20];

    sb          = new();
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = REG_POLICY;
    cfg_wdata   = '0;
    req_valid   = 1'b0;
    request_key = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under the reset settings: extreme keys, repeats that
    // must hit, and fills of empty slots in order
    directed = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000,
                 16'h0001, 16'h7FFF, 16'hFFFE, 16'h5555, 16'hAAAA,
                 16'h5555, 16'h0000, 16'hAAAA, 16'h00FF, 16'hFF00,
                 16'h8000, 16'h0001, 16'hFFFF, 16'h1234, 16'h1234};
    send_idle_pct = 11;
    recv_idle_pct = 57;
    foreach (directed[i]) send_lookup(directed[i]);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin pol = POL_LFU;    seed = 16'h0000; end
        1:       begin pol = POL_MFU;    seed = 16'hFFFF; end
        2:       begin pol = POL_MRU;    seed = 16'h0001; end
        3:       begin pol = POL_LRU;    seed = 16'hACE1; end
        4:       begin pol = POL_RAND;   seed = 16'h0000; end
        5:       begin pol = POL_RAND;   seed = 16'hFFFF; end
        6:       begin pol = POL_SPARE5; seed = CFG_W'($urandom); end
        7:       begin pol = POL_SPARE6; seed = CFG_W'($urandom); end
        8:       begin pol = POL_SPARE7; seed = CFG_W'($urandom); end
        default: begin pol = POL_RAND;   seed = 16'h8000; end
      endcase
      // idling: sender light and receiver heavy, then swapped, then none
      if (p < 4) begin
        send_idle_pct = 11;
        recv_idle_pct = 57;
      end else if (p < 7) begin
        send_idle_pct = 57;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // upper bits of the policy word are junk, only the low field counts
      pol_word                = CFG_W'($urandom);
      pol_word[POL_W-1:0]     = pol;
      write_reg(REG_POLICY, pol_word);
      write_reg(REG_SEED, seed);

      run_lookups(PHASE_WORDS / 2, (p % 2 == 0) ? 40 : 90);
      if (p == 1 || p == 8) pressure_burst();
      // a mid-phase pause until every reply is in
      if (p == 2) wait_drained();
      run_lookups(PHASE_WORDS - PHASE_WORDS / 2, (p % 2 == 0) ? 90 : 40);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("lookups checked: %0d hits, %0d empty-slot fills, %0d evictions",
             sb.hits, sb.fills, sb.evictions);
    $display("%0d register writes across all victim rules, seeds and idling mixes",
             settings_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
